// File: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Request payload structs, status codes, operation codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int MAG_W = 64;

	typedef enum logic [1:0] {CMD_ADD = 2'd0, CMD_SUB = 2'd1, CMD_MUL = 2'd2, CMD_DIV = 2'd3} cmd_t;
	typedef enum logic [1:0] {ST_OK = 2'd0, ST_DIVZ = 2'd1, ST_ZDEN = 2'd2, ST_OVF = 2'd3} status_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] a_num;
		logic [30:0]        a_den;
		logic signed [31:0] b_num;
		logic [30:0]        b_den;
	} req_in_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0]        res_den;
		logic [1:0]         status;
	} req_out_t;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_GCD, S_DIVN, S_DIVD, S_DONE
	} state_t;
endpackage
`default_nettype wire

// File: rtl/rau_divider.sv
// ----------------------------------------------------------------------------
// rau_divider: bit-serial 64-bit unsigned divider
// One quotient bit per cycle; gives quotient and remainder after 64 steps.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_divider import rau_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [MAG_W-1:0]  dividend,
	input  wire logic [MAG_W-1:0]  divisor,
	output logic                   done,
	output logic [MAG_W-1:0]       quot,
	output logic [MAG_W-1:0]       rem
);
	logic [MAG_W-1:0] q_q, r_q, d_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [MAG_W:0] trial;

	// The remainder shifted left with the next dividend bit, less the divisor.
	assign trial = {r_q, q_q[MAG_W-1]} - {1'b0, d_q};

	// Done is raised for one cycle after the last step, when quot and rem hold
	// their final values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'(MAG_W);
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			done_q <= (cnt_q == 7'd1);
			if (cnt_q == 7'd1) busy_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!trial[MAG_W]) begin
				r_q <= trial[MAG_W-1:0];
				q_q <= {q_q[MAG_W-2:0], 1'b1};
			end else begin
				r_q <= {r_q[MAG_W-2:0], q_q[MAG_W-1]};
				q_q <= {q_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign rem  = r_q;
endmodule
`default_nettype wire

// File: rtl/rational_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core: fraction add, subtract, multiply, divide
// Exact cross products, gcd reduction and range check under one sequencer.
// ----------------------------------------------------------------------------
// Usage: a request on the in channel (in_valid/in_stall, payload in_data)
// carries an operation and two fractions. One result request leaves on the
// out channel (out_valid/out_stall, payload out_data) for each input.
// The block takes one request at a time. The cross products are formed by
// one 32x32 multiplier used two or three times. The Euclidean gcd then
// runs on a bit-serial divider shared with the two final exact divisions;
// the divider runs once for every remainder step and once for each of the
// numerator and the denominator. Add and subtract pass S_MUL1, S_MUL2 and
// S_MUL3 before S_COMB; multiply and divide skip S_MUL3. A zero denominator
// or a division by zero gives its result from S_MUL1; a zero result leaves
// from S_COMB. The result sits in an output register. While the receiver
// stalls it holds and the block stays busy; in_stall is low only when the
// block is idle and the output register is empty or being taken.
// Reset clears the sequencer and the output valid; no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arithmetic_unit_core import rau_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire req_in_t  in_data,
	output logic          out_valid,
	input  wire logic     out_stall,
	output req_out_t      out_data
);
	localparam logic [MAG_W-1:0] LIMIT = (MAG_W'(1) << (VALUE_WIDTH - 1)) - MAG_W'(1);

	state_t state_q, state_d;
	req_in_t req_q;
	logic an_q, bn_q, rneg_q, s1_q, s2_q;
	logic [31:0] am_q, bm_q;
	logic [MAG_W-1:0] m1_q, m2_q, rd_q, rn_q, x_q, y_q;
	logic out_valid_q;
	req_out_t out_q;

	// The shared multiplier: one 32x32 product per cycle.
	logic [31:0] mul_a, mul_b;
	logic [MAG_W-1:0] mul_p;
	assign mul_p = MAG_W'(mul_a) * MAG_W'(mul_b);

	logic div_start, div_done;
	logic [MAG_W-1:0] div_n, div_d, div_q, div_r;
	rau_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_n),
		.divisor(div_d), .done(div_done), .quot(div_q), .rem(div_r)
	);

	logic accept, out_free, fin, fin_err;
	logic [1:0] fin_st;
	logic div_busy_q;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !(state_q == S_IDLE && out_free);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		mul_a = am_q;
		mul_b = {1'b0, req_q.b_den};
		unique case (state_q)
			S_MUL1: begin
				mul_a = (req_q.cmd == CMD_MUL) ? am_q : am_q;
				mul_b = (req_q.cmd == CMD_MUL) ? bm_q : {1'b0, req_q.b_den};
			end
			S_MUL2: begin
				mul_a = {1'b0, req_q.a_den};
				mul_b = (req_q.cmd == CMD_ADD || req_q.cmd == CMD_SUB) ? bm_q
					: (req_q.cmd == CMD_DIV) ? bm_q : {1'b0, req_q.b_den};
			end
			S_MUL3: begin
				mul_a = {1'b0, req_q.a_den};
				mul_b = {1'b0, req_q.b_den};
			end
			default: ;
		endcase
	end

	// Next state and sequencer outputs.
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_n     = x_q;
		div_d     = y_q;
		fin       = 1'b0;
		fin_err   = 1'b1;
		fin_st    = ST_OK;
		unique case (state_q)
			S_IDLE: if (accept) state_d = S_MUL1;
			S_MUL1: begin
				if (req_q.a_den == '0 || req_q.b_den == '0) begin
					fin = 1'b1; fin_st = ST_ZDEN; state_d = S_IDLE;
				end else if (req_q.cmd == CMD_DIV && bm_q == '0) begin
					fin = 1'b1; fin_st = ST_DIVZ; state_d = S_IDLE;
				end else begin
					state_d = S_MUL2;
				end
			end
			S_MUL2: state_d = (req_q.cmd == CMD_ADD || req_q.cmd == CMD_SUB) ? S_MUL3 : S_COMB;
			S_MUL3: state_d = S_COMB;
			S_COMB: begin
				if (rn_q == '0) begin
					fin = 1'b1; fin_st = ST_OK; state_d = S_IDLE;
				end else begin
					div_start = 1'b1; div_n = rn_q; div_d = rd_q; state_d = S_GCD;
				end
			end
			S_GCD: begin
				if (div_done) begin
					div_start = 1'b1;
					if (div_r == '0) begin
						div_n = rn_q; div_d = y_q; state_d = S_DIVN;
					end else begin
						div_n = y_q; div_d = div_r;
					end
				end
			end
			S_DIVN: if (div_done) begin
				div_start = 1'b1; div_n = rd_q; div_d = y_q; state_d = S_DIVD;
			end
			S_DIVD: if (div_done) begin
				fin = 1'b1; state_d = S_IDLE;
				if (x_q > LIMIT || div_q > LIMIT) fin_st = ST_OVF;
				else fin_err = 1'b0;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			div_busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			div_busy_q <= div_start ? 1'b1 : (div_done ? 1'b0 : div_busy_q);
			if (fin) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_data;
			an_q  <= in_data.a_num[31];
			bn_q  <= in_data.b_num[31];
			am_q  <= in_data.a_num[31] ? 32'(-in_data.a_num) : in_data.a_num;
			bm_q  <= in_data.b_num[31] ? 32'(-in_data.b_num) : in_data.b_num;
		end
		unique case (state_q)
			S_MUL1: begin
				m1_q <= mul_p;
				if (req_q.cmd == CMD_MUL || req_q.cmd == CMD_DIV) begin
					rn_q <= mul_p; rneg_q <= an_q ^ bn_q;
				end
				s1_q <= an_q;
			end
			S_MUL2: begin
				m2_q <= mul_p;
				if (req_q.cmd == CMD_MUL || req_q.cmd == CMD_DIV) rd_q <= mul_p;
				s2_q <= bn_q ^ (req_q.cmd == CMD_SUB);
			end
			S_MUL3: begin
				rd_q <= mul_p;
				// Sign of a zero product never matters: the other product sets it, or rn is zero.
				if (s1_q == s2_q) begin
					rn_q <= m1_q + m2_q; rneg_q <= s1_q;
				end else if (m1_q >= m2_q) begin
					rn_q <= m1_q - m2_q; rneg_q <= s1_q;
				end else begin
					rn_q <= m2_q - m1_q; rneg_q <= s2_q;
				end
			end
			S_COMB: y_q <= rd_q;
			S_GCD: if (div_done && div_r != '0) y_q <= div_r;
			S_DIVN: if (div_done) x_q <= div_q;
			default: ;
		endcase
		if (fin) begin
			out_q.status  <= fin_st;
			out_q.res_num <= fin_err ? 32'sd0
				: (rneg_q ? 32'(-x_q[31:0]) : x_q[31:0]);
			out_q.res_den <= fin_err ? 31'd1 : div_q[30:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("accepted while busy");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");
	a_div_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> div_busy_q) else $error("divider done when idle");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != ST_OK) |-> (out_data.res_num == 0
		&& out_data.res_den == 31'd1)) else $error("error result not 0/1");
endmodule
`default_nettype wire

// File: tb/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker: result checker for the rational arithmetic unit
// Watches both channels, computes each expected reduced fraction and compares.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_checker import rau_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic     clk,
	input  wire logic     in_valid,
	input  wire logic     in_stall,
	input  wire req_in_t  in_data,
	input  wire logic     out_valid,
	input  wire logic     out_stall,
	input  wire req_out_t out_data,
	output int            fail_count,
	output int            pending_count,
	output int            checked_count
);
	req_out_t fraction_q[$];

	function automatic logic [127:0] euclid_gcd(input logic [127:0] x, input logic [127:0] y);
		logic [127:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic req_out_t reduce_fraction(input req_in_t r);
		req_out_t o;
		logic an, bn, s1, s2, rneg;
		logic [127:0] am, bm, ad, bd, m1, m2, rn, rd, g, lim;
		o.res_num = 0;
		o.res_den = 1;
		o.status = ST_OK;
		lim = (128'd1 << (VALUE_WIDTH - 1)) - 1;
		an = r.a_num[31];
		bn = r.b_num[31];
		am = an ? 128'(33'h1_0000_0000 - {1'b0, r.a_num}) : 128'(r.a_num);
		bm = bn ? 128'(33'h1_0000_0000 - {1'b0, r.b_num}) : 128'(r.b_num);
		ad = 128'(r.a_den);
		bd = 128'(r.b_den);
		if (ad == 0 || bd == 0) begin
			o.status = ST_ZDEN;
			return o;
		end
		case (cmd_t'(r.cmd))
			CMD_ADD, CMD_SUB: begin
				m1 = am * bd;
				m2 = ad * bm;
				s1 = an && m1 != 0;
				s2 = bn && m2 != 0;
				if (r.cmd == CMD_SUB && m2 != 0) s2 = !s2;
				if (s1 == s2) begin
					rn = m1 + m2;
					rneg = s1;
				end else if (m1 >= m2) begin
					rn = m1 - m2;
					rneg = s1;
				end else begin
					rn = m2 - m1;
					rneg = s2;
				end
				rd = ad * bd;
			end
			CMD_MUL: begin
				rn = am * bm;
				rneg = an != bn;
				rd = ad * bd;
			end
			default: begin
				if (bm == 0) begin
					o.status = ST_DIVZ;
					return o;
				end
				rn = am * bd;
				rneg = an != bn;
				rd = ad * bm;
			end
		endcase
		if (rn == 0) return o;
		g = euclid_gcd(rn, rd);
		rn = rn / g;
		rd = rd / g;
		if (rn > lim || rd > lim) begin
			o.status = ST_OVF;
			return o;
		end
		o.res_num = rneg ? -rn[31:0] : rn[31:0];
		o.res_den = rd[30:0];
		return o;
	endfunction

	// The counters are two-state and start at zero.
	always @(posedge clk) begin
		req_out_t want;
		if (in_valid && !in_stall) fraction_q.push_back(reduce_fraction(in_data));
		if (out_valid && !out_stall) begin
			if (fraction_q.size() == 0) begin
				$display("%0t: unexpected result %0d/%0d status %0d", $time,
					out_data.res_num, out_data.res_den, out_data.status);
				fail_count <= fail_count + 1;
			end else begin
				want = fraction_q.pop_front();
				checked_count <= checked_count + 1;
				if (want !== out_data) begin
					$display("%0t: expected %0d/%0d status %0d, got %0d/%0d status %0d",
						$time, want.res_num, want.res_den, want.status,
						out_data.res_num, out_data.res_den, out_data.status);
					fail_count <= fail_count + 1;
				end
			end
		end
		pending_count <= fraction_q.size();
	end
endmodule
`default_nettype wire

// File: tb/tb_rational_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit_core: regression bench for the fraction unit
// Directed corner requests, then random fractions of varied magnitude, with
// random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_rational_arithmetic_unit_core;
	import rau_pkg::*;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_stall;
	req_in_t  in_data = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	req_out_t out_data;
	int       fail_count, pending_count, checked_count;
	int       sent_count = 0;
	// The output side runs its own pattern; these set when it may idle.
	logic     calm_phase = 1'b0;
	logic     hold_off = 1'b0;

	always #5 clk = ~clk;

	rational_arithmetic_unit_core uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data)
	);

	rau_checker chk (
		.clk(clk), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.fail_count(fail_count), .pending_count(pending_count),
		.checked_count(checked_count)
	);

	// A numerator drawn with a random magnitude class so that small values,
	// which reduce often, and full-scale values, which overflow, both appear.
	function automatic logic [31:0] pick_num();
		case ($urandom_range(0, 5))
			0: return 32'($urandom_range(0, 3)) - 32'd1;
			1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			2: return $urandom;
			3: return 32'($signed($urandom_range(0, 2000)) - 1000);
			default: return $urandom_range(0, 1) ? 32'($urandom_range(0, 65535))
				: -32'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [30:0] pick_den();
		case ($urandom_range(0, 5))
			0: return ($urandom_range(0, 9) == 0) ? 31'd0 : 31'd1;
			1: return 31'h7FFF_FFFF;
			2: return 31'($urandom);
			3: return 31'($urandom_range(1, 1000));
			default: return 31'($urandom_range(1, 65535));
		endcase
	endfunction

	// Offers one request and holds it, untouched, until it is accepted.
	// Valid is left high afterward so that back-to-back requests never see
	// a lower-and-raise within one time step.
	task automatic send_request(input req_in_t r, input bit may_idle);
		while (may_idle && $urandom_range(0, 99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_count++;
	endtask

	function automatic req_in_t make_req(input cmd_t c, input logic [31:0] an,
		input logic [30:0] ad, input logic [31:0] bn, input logic [30:0] bd);
		req_in_t r;
		r.cmd = c;
		r.a_num = an;
		r.a_den = ad;
		r.b_num = bn;
		r.b_den = bd;
		return r;
	endfunction

	// Receiver: random stalls most of the time, none while calm_phase is set,
	// and a solid stall for the whole hold-off.
	always @(posedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else if (calm_phase) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(0, 99) < 19);
	end

	// Hold-off process: once a few hundred requests are through, stall the
	// output for a long count of cycles while the sender keeps offering.
	initial begin
		wait (sent_count >= 300);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (3000) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#1_000_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		req_in_t r;
		int drain;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners: each operation, zero denominators (also with a
		// zero numerator), division by a zero fraction, zero results, the
		// most negative numerator and full-scale overflow.
		send_request(make_req(CMD_ADD, 32'd1, 31'd2, 32'd1, 31'd3), 1'b0);
		send_request(make_req(CMD_SUB, 32'd1, 31'd2, 32'd1, 31'd2), 1'b0);
		send_request(make_req(CMD_MUL, -32'd3, 31'd4, 32'd8, 31'd9), 1'b0);
		send_request(make_req(CMD_DIV, 32'd5, 31'd7, -32'd10, 31'd21), 1'b0);
		send_request(make_req(CMD_ADD, 32'd0, 31'd0, 32'd1, 31'd1), 1'b0);
		send_request(make_req(CMD_DIV, 32'd1, 31'd1, 32'd0, 31'd0), 1'b0);
		send_request(make_req(CMD_MUL, 32'd3, 31'd5, 32'd2, 31'd0), 1'b0);
		send_request(make_req(CMD_DIV, 32'd3, 31'd5, 32'd0, 31'd7), 1'b0);
		send_request(make_req(CMD_MUL, 32'd0, 31'd5, -32'd9, 31'd7), 1'b0);
		send_request(make_req(CMD_ADD, 32'h8000_0000, 31'd1, 32'd0, 31'd1), 1'b0);
		send_request(make_req(CMD_MUL, 32'h8000_0000, 31'd1, -32'd1, 31'd2), 1'b0);
		send_request(make_req(CMD_ADD, 32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 31'd1), 1'b0);
		send_request(make_req(CMD_SUB, 32'h8000_0000, 31'h7FFF_FFFF,
			32'h7FFF_FFFF, 31'h7FFF_FFFF), 1'b0);
		send_request(make_req(CMD_DIV, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
			32'h8000_0000, 31'h7FFF_FFFF), 1'b0);
		send_request(make_req(CMD_MUL, 32'h7FFF_FFFF, 31'h7FFF_FFFE,
			32'h7FFF_FFFE, 31'h7FFF_FFFF), 1'b0);
		send_request(make_req(CMD_SUB, -32'd1, 31'd3, 32'd1, 31'd3), 1'b0);

		// Random part; one stretch in the middle runs with no idling.
		for (int i = 0; i < 1350; i++) begin
			r = make_req(cmd_t'($urandom_range(0, 3)), pick_num(), pick_den(),
				pick_num(), pick_den());
			calm_phase <= (i >= 600 && i < 800);
			send_request(r, !(i >= 600 && i < 800));
		end
		in_valid <= 1'b0;
		calm_phase <= 1'b0;

		drain = 0;
		while (pending_count != 0 && drain < 2_000_000) begin
			@(posedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);

		$display("Sent %0d requests over all four operations and error cases;", sent_count);
		$display("checked %0d results, with a long output hold-off.", checked_count);
		if (fail_count == 0 && pending_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
